/* rtl/core/irqlat_pkg.sv */
// ============================================================================
// irqlat_pkg
// Shared constants for the interrupt latency min/max/average statistics block.
// ============================================================================
`default_nettype none

package irqlat_pkg;

    // default sizing of the statistics store
    localparam int ENTRY_COUNT_DEF = 16;
    localparam int TICK_WIDTH_DEF  = 32;

    // port field widths
    localparam int VECTOR_W   = 8;
    localparam int DURATION_W = 32;
    localparam int RESULT_W   = 32;
    localparam int SHIFT_W    = 5;

    // vector bits that pick the statistics entry
    localparam int SEL_LSB   = 4;
    localparam int SEL_W     = VECTOR_W - SEL_LSB;
    localparam int SEL_COUNT = 1 << SEL_W;

    // moving average weight after reset
    localparam logic [SHIFT_W-1:0] AVG_SHIFT_RESET = 5'd7;

endpackage

`default_nettype wire

/* rtl/core/irq_latency_min_max_avg_stats.sv */
// ============================================================================
// irq_latency_min_max_avg_stats
// Per-interrupt-line service time statistics (min, max, moving average).
// ============================================================================
// Each input word carries a vector number and a measured duration; vector
// bits 7..4 (modulo ENTRY_COUNT) pick a statistics entry, and one result word
// with the entry's updated min, average and max comes back for every input.
// The block takes one word per cycle while the result side does not stall: the
// word's read of the statistics memory is issued at acceptance, the update and
// write-back follow in the update stage, which loads the output register. The
// single read and single write port of the memory set that rate; a write to
// the entry that the next word reads is forwarded. Backpressure on the result
// side stalls the update stage, and input is taken again as soon as the
// output register frees. Entries are empty after reset with no clearing pass.
// avg_shift may be written only while no word is in flight.
// ============================================================================
`default_nettype none

module irq_latency_min_max_avg_stats #(
    parameter int ENTRY_COUNT = irqlat_pkg::ENTRY_COUNT_DEF,
    parameter int TICK_WIDTH  = irqlat_pkg::TICK_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [irqlat_pkg::SHIFT_W-1:0]   cfg_wdata,
    // input words
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [irqlat_pkg::VECTOR_W-1:0]  s_vector_number,
    input  wire logic [irqlat_pkg::DURATION_W-1:0] s_duration_ticks,
    // result words
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [irqlat_pkg::RESULT_W-1:0]  m_entry_min,
    output logic      [irqlat_pkg::RESULT_W-1:0]  m_entry_avg,
    output logic      [irqlat_pkg::RESULT_W-1:0]  m_entry_max
);

    localparam int IDX_W  = $clog2(ENTRY_COUNT);
    localparam int DATA_W = 3 * TICK_WIDTH;

    logic [irqlat_pkg::SHIFT_W-1:0]  avg_shift_reg;
    logic [IDX_W-1:0]                slot_lut [irqlat_pkg::SEL_COUNT];
    logic [IDX_W-1:0]                in_idx;
    logic                            in_accept;
    logic                            advance;

    logic                            st_valid_reg;
    logic [IDX_W-1:0]                st_idx_reg;
    logic [TICK_WIDTH-1:0]           st_tick_reg;

    logic                            byp_valid_reg;
    logic [IDX_W-1:0]                byp_idx_reg;
    logic [DATA_W-1:0]               byp_data_reg;

    logic [DATA_W-1:0]               ram_rd_data;
    logic [DATA_W-1:0]               cur_entry;
    logic [TICK_WIDTH-1:0]           upd_min;
    logic [TICK_WIDTH-1:0]           upd_avg;
    logic [TICK_WIDTH-1:0]           upd_max;
    logic [DATA_W-1:0]               upd_entry;

    logic                            m_valid_reg;
    logic [irqlat_pkg::RESULT_W-1:0] m_min_reg;
    logic [irqlat_pkg::RESULT_W-1:0] m_avg_reg;
    logic [irqlat_pkg::RESULT_W-1:0] m_max_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_shift_reg <= irqlat_pkg::AVG_SHIFT_RESET;
        end else if (cfg_valid) begin
            avg_shift_reg <= cfg_wdata;
        end
    end

    // entry select: vector high bits folded modulo the entry count
    for (genvar i = 0; i < irqlat_pkg::SEL_COUNT; i++) begin : g_slot
        localparam int SLOT = i % ENTRY_COUNT;
        assign slot_lut[i] = IDX_W'(SLOT);
    end

    assign in_idx = slot_lut[s_vector_number[irqlat_pkg::VECTOR_W-1:irqlat_pkg::SEL_LSB]];

    // handshake: update stage moves when the output register can take it
    assign advance   = st_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !st_valid_reg || advance;
    assign in_accept = s_valid && s_ready;

    // update stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (in_accept) begin
            st_valid_reg <= 1'b1;
        end else if (advance) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            st_idx_reg  <= in_idx;
            st_tick_reg <= TICK_WIDTH'(s_duration_ticks);
        end
    end

    // statistics memory
    irqlat_stat_ram #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_stat_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_idx  (in_idx),
        .rd_data (ram_rd_data),
        .wr_en   (advance),
        .wr_idx  (st_idx_reg),
        .wr_data (upd_entry)
    );

    // forward the last write when it hit the entry being updated
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (advance) begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byp_idx_reg  <= st_idx_reg;
            byp_data_reg <= upd_entry;
        end
    end

    assign cur_entry = (byp_valid_reg && (byp_idx_reg == st_idx_reg)) ?
                       byp_data_reg : ram_rd_data;

    // min / max / moving average update
    irqlat_update #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_update (
        .cur_min   (cur_entry[TICK_WIDTH-1:0]),
        .cur_avg   (cur_entry[2*TICK_WIDTH-1:TICK_WIDTH]),
        .cur_max   (cur_entry[DATA_W-1:2*TICK_WIDTH]),
        .tick      (st_tick_reg),
        .avg_shift (avg_shift_reg),
        .new_min   (upd_min),
        .new_avg   (upd_avg),
        .new_max   (upd_max)
    );

    assign upd_entry = {upd_max, upd_avg, upd_min};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_min_reg <= irqlat_pkg::RESULT_W'(upd_min);
            m_avg_reg <= irqlat_pkg::RESULT_W'(upd_avg);
            m_max_reg <= irqlat_pkg::RESULT_W'(upd_max);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_entry_min = m_min_reg;
    assign m_entry_avg = m_avg_reg;
    assign m_entry_max = m_max_reg;

    // an accepted word is in the update stage in the next cycle
    a_accept_to_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> st_valid_reg)
        else $error("accepted word missing from update stage");

    // a new result only comes from the update stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st_valid_reg))
        else $error("result without an update");

    // the updated entry keeps min at or below max
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg |-> (upd_min <= upd_max))
        else $error("entry min above max");

    // an empty entry is loaded with the duration
    a_empty_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && (cur_entry[2*TICK_WIDTH-1:TICK_WIDTH] == '0)) |->
        ((upd_min == st_tick_reg) && (upd_max == st_tick_reg)
         && (upd_avg == st_tick_reg)))
        else $error("empty entry not loaded with duration");

endmodule

`default_nettype wire

/* rtl/core/irqlat_stat_ram.sv */
// ============================================================================
// irqlat_stat_ram
// Statistics store: one synchronous memory holding {max, avg, min} for each
// entry, one read and one write port, plus per-entry valid flops so that an
// entry not yet written since reset reads as all zero.
// ============================================================================
`default_nettype none

module irqlat_stat_ram #(
    parameter int ENTRY_COUNT = irqlat_pkg::ENTRY_COUNT_DEF,
    parameter int TICK_WIDTH  = irqlat_pkg::TICK_WIDTH_DEF,
    localparam int IDX_W      = $clog2(ENTRY_COUNT),
    localparam int DATA_W     = 3 * TICK_WIDTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_idx,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0]      mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;

    // memory array: write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    // entry valid flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* rtl/core/irqlat_update.sv */
// ============================================================================
// irqlat_update
// Statistics update: loads an empty entry with the new duration, otherwise
// tracks min and max by compare and moves the average by avg - avg>>s + t>>s.
// ============================================================================
`default_nettype none

module irqlat_update #(
    parameter int TICK_WIDTH = irqlat_pkg::TICK_WIDTH_DEF
) (
    input  wire logic [TICK_WIDTH-1:0]          cur_min,
    input  wire logic [TICK_WIDTH-1:0]          cur_avg,
    input  wire logic [TICK_WIDTH-1:0]          cur_max,
    input  wire logic [TICK_WIDTH-1:0]          tick,
    input  wire logic [irqlat_pkg::SHIFT_W-1:0] avg_shift,
    output logic      [TICK_WIDTH-1:0]          new_min,
    output logic      [TICK_WIDTH-1:0]          new_avg,
    output logic      [TICK_WIDTH-1:0]          new_max
);

    logic                  empty;
    logic [TICK_WIDTH-1:0] avg_step;

    // a zero average marks an empty entry
    assign empty = (cur_avg == '0);

    // moving average, wrapping at the store width
    assign avg_step = cur_avg - (cur_avg >> avg_shift) + (tick >> avg_shift);

    always_comb begin
        if (empty) begin
            new_min = tick;
            new_avg = tick;
            new_max = tick;
        end else begin
            new_min = (tick < cur_min) ? tick : cur_min;
            new_max = (tick > cur_max) ? tick : cur_max;
            new_avg = avg_step;
        end
    end

endmodule

`default_nettype wire

/* bench/irq_latency_min_max_avg_stats_tb.sv */
// ============================================================================
// irq_latency_min_max_avg_stats_tb
// Self-checking bench for the per-line min/max/moving-average statistics block.
// ============================================================================
// Words of vector number and duration go in over a valid/ready channel. Each
// accepted word runs through a local model of the 16 statistics entries, and
// the model's min, average and max are queued. Every result word is checked
// field by field against the oldest queued entry. Directed words cover empty
// entries, zero and full-scale durations and the shift extremes. Random
// phases then hit a few hot entries hard under different idling mixes and
// average shift settings. The shift is only rewritten once the block is idle.
// ============================================================================

module irq_latency_min_max_avg_stats_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // field widths and entry select taken from the shared package
    localparam int VECTOR_W   = irqlat_pkg::VECTOR_W;
    localparam int DURATION_W = irqlat_pkg::DURATION_W;
    localparam int RESULT_W   = irqlat_pkg::RESULT_W;
    localparam int SHIFT_W    = irqlat_pkg::SHIFT_W;
    localparam int SEL_LSB    = irqlat_pkg::SEL_LSB;
    localparam int SEL_W      = irqlat_pkg::SEL_W;
    localparam int SEL_COUNT  = irqlat_pkg::SEL_COUNT;
    localparam logic [SHIFT_W-1:0] AVG_SHIFT_RESET = irqlat_pkg::AVG_SHIFT_RESET;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 6;
    localparam int REPORT_MAX   = 10;

    // one result word: updated statistics of the selected entry
    typedef struct packed {
        logic [RESULT_W-1:0] min_ticks;
        logic [RESULT_W-1:0] avg_ticks;
        logic [RESULT_W-1:0] max_ticks;
    } entry_stats_t;

    logic                  aclk;
    logic                  aresetn          = 1'b0;
    logic                  cfg_valid        = 1'b0;
    logic                  cfg_ready;
    logic [SHIFT_W-1:0]    cfg_wdata        = '0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [VECTOR_W-1:0]   s_vector_number  = '0;
    logic [DURATION_W-1:0] s_duration_ticks = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic [RESULT_W-1:0]   m_entry_min;
    logic [RESULT_W-1:0]   m_entry_avg;
    logic [RESULT_W-1:0]   m_entry_max;

    // local copy of the statistics stores and the shift setting
    logic [RESULT_W-1:0] min_model [SEL_COUNT];
    logic [RESULT_W-1:0] avg_model [SEL_COUNT];
    logic [RESULT_W-1:0] max_model [SEL_COUNT];
    logic [SHIFT_W-1:0]  shift_model = AVG_SHIFT_RESET;

    entry_stats_t stats_due[$];

    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int mismatches      = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int shift_writes    = 0;

    irq_latency_min_max_avg_stats dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vector_number  (s_vector_number),
        .s_duration_ticks (s_duration_ticks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_entry_min      (m_entry_min),
        .m_entry_avg      (m_entry_avg),
        .m_entry_max      (m_entry_max)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // entries start empty
    initial begin
        for (int i = 0; i < SEL_COUNT; i++) begin
            min_model[i] = '0;
            avg_model[i] = '0;
            max_model[i] = '0;
        end
    end

    // update one entry the way the block should, return its new statistics
    function automatic entry_stats_t predict_entry_update(input logic [VECTOR_W-1:0] vec,
                                                          input logic [DURATION_W-1:0] dur);
        logic [SEL_W-1:0]    slot;
        logic [RESULT_W-1:0] avg_next;
        entry_stats_t        stats;
        slot = vec[VECTOR_W-1:SEL_LSB];
        if (avg_model[slot] == '0) begin
            // empty entry: load everything with the duration
            min_model[slot] = dur;
            avg_model[slot] = dur;
            max_model[slot] = dur;
        end else begin
            if (dur < min_model[slot]) min_model[slot] = dur;
            if (dur > max_model[slot]) max_model[slot] = dur;
            avg_next = avg_model[slot] - (avg_model[slot] >> shift_model)
                       + (dur >> shift_model);
            avg_model[slot] = avg_next;
        end
        stats.min_ticks = min_model[slot];
        stats.avg_ticks = avg_model[slot];
        stats.max_ticks = max_model[slot];
        return stats;
    endfunction

    // present one word, with random idle cycles ahead of it
    task automatic send_word(input logic [VECTOR_W-1:0] vec, input logic [DURATION_W-1:0] dur);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_vector_number  <= vec;
        s_duration_ticks <= dur;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        stats_due.push_back(predict_entry_update(vec, dur));
        words_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // shift register write, only with the block idle
    task automatic write_avg_shift(input logic [SHIFT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        shift_model = value;
        shift_writes++;
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin : check_results
        entry_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with nothing expected: min %h avg %h max %h",
                             $realtime, m_entry_min, m_entry_avg, m_entry_max);
            end else begin
                want = stats_due.pop_front();
                results_checked++;
                if (m_entry_min !== want.min_ticks || m_entry_avg !== want.avg_ticks ||
                    m_entry_max !== want.max_ticks) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: mismatch: min %h/%h avg %h/%h max %h/%h (exp/got)",
                                 $realtime, want.min_ticks, m_entry_min, want.avg_ticks,
                                 m_entry_avg, want.max_ticks, m_entry_max);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // empty entries, zero and full-scale durations, min/max both ways
    task automatic test_empty_and_extremes();
        send_word(8'h00, 32'h0000_0000);
        send_word(8'h0F, 32'd100);
        send_word(8'h05, 32'h0000_0000);
        send_word(8'h00, 32'hFFFF_FFFF);
        send_word(8'hF0, 32'hFFFF_FFFF);
        send_word(8'hFF, 32'h0000_0001);
        send_word(8'hA5, 32'h5A5A_5A5A);
        send_word(8'h5A, 32'hA5A5_A5A5);
        drain_results();
    endtask

    // shift of zero, shift far above the intended range, and the range ends
    task automatic test_shift_extremes();
        write_avg_shift(5'd0);
        send_word(8'h20, 32'd500);
        send_word(8'h2A, 32'd20);
        // zero duration with shift zero empties the entry again
        send_word(8'h2F, 32'd0);
        send_word(8'h21, 32'd900);
        write_avg_shift(5'd31);
        send_word(8'h30, 32'd1000);
        send_word(8'h3C, 32'hFFFF_FFFF);
        write_avg_shift(5'd16);
        send_word(8'h30, 32'h1234_5678);
        write_avg_shift(5'd1);
        send_word(8'h3E, 32'hFFFF_FFFF);
        send_word(8'h31, 32'd0);
        drain_results();
    endtask

    // random traffic, mostly repeated hits on a few entries
    task automatic test_random_traffic(input logic [SHIFT_W-1:0] shift, input int src_pct,
                                       input int sink_pct, input int count);
        logic [SEL_W-1:0]      hot [3];
        logic [DURATION_W-1:0] base_ticks [SEL_COUNT];
        logic [VECTOR_W-1:0]   vec;
        logic [DURATION_W-1:0] dur;
        int                    kind;
        write_avg_shift(shift);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < 3; i++) hot[i] = SEL_W'($urandom);
        for (int i = 0; i < SEL_COUNT; i++) base_ticks[i] = $urandom_range(100000, 1000);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70)
                vec = {hot[$urandom_range(2)], SEL_LSB'($urandom)};
            else
                vec = VECTOR_W'($urandom);
            kind = $urandom_range(99);
            if (kind < 60)
                dur = base_ticks[vec[VECTOR_W-1:SEL_LSB]] + $urandom_range(511) - 256;
            else if (kind < 75)
                dur = $urandom_range(15);
            else if (kind < 85) begin
                case ($urandom_range(3))
                    0: dur = 32'h0000_0000;
                    1: dur = 32'hFFFF_FFFF;
                    2: dur = 32'h8000_0000;
                    default: dur = 32'h7FFF_FFFF;
                endcase
            end else
                dur = $urandom();
            send_word(vec, dur);
        end
        drain_results();
    endtask

    // run timeout
    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge aclk);
        $display("irq_latency_min_max_avg_stats_tb: errors");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_extremes();
        test_shift_extremes();
        test_random_traffic(5'd7, 0, 0, 190);
        test_random_traffic(5'd3, 86, 0, 180);
        test_random_traffic(5'd16, 0, 86, 180);
        test_random_traffic(SHIFT_W'($urandom_range(31)), 8, 8, 180);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (SETTLE_TICKS) @(posedge aclk);
        mismatches += stats_due.size();

        $display("covered %0d words, %0d results checked, %0d shift writes, %0d mismatches",
                 words_sent, results_checked, shift_writes, mismatches);
        $display("idling mixes: none, sender 86%%, receiver 86%%, both 8%%");
        if (mismatches == 0)
            $display("irq_latency_min_max_avg_stats_tb: clean");
        else
            $display("irq_latency_min_max_avg_stats_tb: errors");
        $finish;
    end

endmodule
